// ===== design/fss_pkg.sv =====
package fss_pkg;

    // Pattern store geometry and field widths
    localparam int PAT_DEPTH = 128;
    localparam int PAT_AW    = 7;
    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 8;
    localparam int POS_W     = 8;
    localparam int SCORE_W   = 8;

    // ASCII folding bounds
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_CAND  = 1'b1
    } op_t;

    // Pattern memory write request
    typedef struct packed
    {
        logic              en;
        logic [PAT_AW-1:0] addr;
        logic [CHAR_W-1:0] data;
    } pat_wr_t;

    // Registered read data: entry at base and at base + 1
    typedef struct packed
    {
        logic [CHAR_W-1:0] rd_lo;
        logic [CHAR_W-1:0] rd_hi;
    } pat_rd_t;

    // One result beat from the match core
    typedef struct packed
    {
        logic               fire;
        logic               matched;
        logic [SCORE_W-1:0] score;
    } fss_result_t;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ===== design/fuzzy_subsequence_scorer.sv =====
// The result beat is registered and valid in the cycle after the string's last beat is accepted.
// One input beat per cycle while no result waits; the match position can advance on each beat
// as the two read ports of the pattern memory prefetch the entry at it and the one after it.
// Reset clears the length register, all string state and the result valid flag.
// Pattern memory contents are undefined after reset until written.
module fuzzy_subsequence_scorer
    import fss_pkg::*;
#(
    parameter int MAX_LEN = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [PAT_AW-1:0]   pattern_index,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                has_char,
    input  logic                string_end,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                matched,
    output logic [SCORE_W-1:0]  score
);

    logic [LEN_W-1:0]   length_reg;
    logic               out_valid_reg, out_valid_next;
    logic               matched_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               item_fire;
    pat_wr_t            wr;
    pat_rd_t            rd;
    logic [PAT_AW-1:0]  rd_base;
    fss_result_t        result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign item_fire = in_valid && in_ready;

    fss_pattern_mem u_mem
    (
        .clk     (clk),
        .wr      (wr),
        .rd_base (rd_base),
        .rd      (rd)
    );

    fss_match_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_fire      (item_fire),
        .opcode         (opcode),
        .pattern_index  (pattern_index),
        .char_code      (char_code),
        .has_char       (has_char),
        .string_end     (string_end),
        .pattern_length (length_reg),
        .rd             (rd),
        .wr             (wr),
        .rd_base        (rd_base),
        .result         (result)
    );

    // Pattern length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= '0;
        else if (cfg_valid && cfg_ready)
            length_reg <= cfg_data;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result.fire)
        begin
            matched_reg <= result.matched;
            score_reg   <= result.score;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign score     = score_reg;

    // A string's last beat yields a result beat on the next cycle
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_CAND && string_end |=> out_valid)
        else $error("string end without result beat");

    // A waiting result blocks new input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted over a stalled result");

    // Score is nonzero exactly when matched
    a_score_vs_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (matched ? (score != '0) : (score == '0)))
        else $error("score inconsistent with matched flag");

endmodule

// ===== design/fss_pattern_mem.sv =====
module fss_pattern_mem
    import fss_pkg::*;
(
    input  logic              clk,
    input  pat_wr_t           wr,
    input  logic [PAT_AW-1:0] rd_base,
    output pat_rd_t           rd
);

    logic [CHAR_W-1:0] mem [PAT_DEPTH];
    logic [CHAR_W-1:0] rd_lo_reg;
    logic [CHAR_W-1:0] rd_hi_reg;
    logic [PAT_AW-1:0] rd_next_addr;

    assign rd_next_addr = rd_base + PAT_AW'(1);

    // One write port, two read ports, read-old-data on a collision
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_lo_reg <= mem[rd_base];
        rd_hi_reg <= mem[rd_next_addr];
    end

    assign rd.rd_lo = rd_lo_reg;
    assign rd.rd_hi = rd_hi_reg;

endmodule

// ===== design/fss_match_core.sv =====
module fss_match_core
    import fss_pkg::*;
#(
    parameter int MAX_LEN = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_fire,
    input  logic              opcode,
    input  logic [PAT_AW-1:0] pattern_index,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              has_char,
    input  logic              string_end,
    input  logic [LEN_W-1:0]  pattern_length,
    input  pat_rd_t           rd,
    output pat_wr_t           wr,
    output logic [PAT_AW-1:0] rd_base,
    output fss_result_t       result
);

    localparam int SEEN_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(MAX_LEN - 1);

    // String state
    logic [POS_W-1:0]   mp_reg, mp_next;
    logic               prev_reg, prev_next;
    logic [POS_W-1:0]   count_reg, count_next;
    logic               bonus_reg, bonus_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;

    // Prefetch bookkeeping and write forwarding
    logic               adv_reg, adv_next;
    logic               clr_reg, clr_next;
    pat_wr_t            fwd_reg;
    logic [CHAR_W-1:0]  first_reg;

    logic [LEN_W-1:0]   eff_len;
    logic [CHAR_W-1:0]  ch;
    logic [CHAR_W-1:0]  cur_pat;
    logic [CHAR_W-1:0]  sel_pat;
    logic               is_cand;
    logic               take;
    logic               hit;
    logic               ok;
    logic [SCORE_W-1:0] score_calc;

    assign eff_len = (pattern_length > LEN_W'(PAT_DEPTH)) ? LEN_W'(PAT_DEPTH) : pattern_length;
    assign ch      = fold_case(char_code);
    assign rd_base = mp_reg[PAT_AW-1:0];

    // Pattern writes go straight to memory
    assign wr.en   = item_fire && (opcode == OP_WRITE);
    assign wr.addr = pattern_index;
    assign wr.data = ch;

    // Pick the match position's entry: last cycle's reads, entry-zero shadow or a forwarded write
    always_comb
    begin
        priority if (clr_reg)
            sel_pat = first_reg;
        else if (adv_reg)
            sel_pat = rd.rd_hi;
        else
            sel_pat = rd.rd_lo;
        cur_pat = (fwd_reg.en && fwd_reg.addr == mp_reg[PAT_AW-1:0]) ? fwd_reg.data : sel_pat;
    end

    assign is_cand = item_fire && (opcode == OP_CAND);
    assign take    = is_cand && has_char && (seen_reg < SEEN_LIMIT);
    assign hit     = (mp_reg < POS_W'(eff_len)) && (ch == cur_pat);

    // Per-character update and end-of-string scoring
    always_comb
    begin
        mp_next    = mp_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        bonus_next = bonus_reg;
        seen_next  = seen_reg;
        adv_next   = 1'b0;
        clr_next   = 1'b0;
        ok         = 1'b0;
        score_calc = '0;

        if (take)
        begin
            if (seen_reg == '0 && eff_len != '0 && ch == first_reg)
            begin
                bonus_next = 1'b1;
            end
            if (hit)
            begin
                if (mp_reg == '0)
                    count_next = POS_W'(1);
                else if (prev_reg)
                    count_next = count_reg + POS_W'(1);
                mp_next   = mp_reg + POS_W'(1);
                prev_next = 1'b1;
                adv_next  = 1'b1;
            end
            else
            begin
                prev_next = 1'b0;
            end
            seen_next = seen_reg + SEEN_W'(1);
        end

        if (is_cand && string_end)
        begin
            ok = (eff_len != '0) && (mp_next >= POS_W'(eff_len));
            if (ok)
            begin
                score_calc = SCORE_W'(count_next) + SCORE_W'(bonus_next);
            end
            mp_next    = '0;
            prev_next  = 1'b0;
            count_next = '0;
            bonus_next = 1'b0;
            seen_next  = '0;
            adv_next   = 1'b0;
            clr_next   = 1'b1;
        end
    end

    assign result.fire    = is_cand && string_end;
    assign result.matched = ok;
    assign result.score   = score_calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mp_reg    <= '0;
            prev_reg  <= 1'b0;
            count_reg <= '0;
            bonus_reg <= 1'b0;
            seen_reg  <= '0;
            adv_reg   <= 1'b0;
            clr_reg   <= 1'b0;
            fwd_reg   <= '0;
        end
        else
        begin
            mp_reg    <= mp_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            bonus_reg <= bonus_next;
            seen_reg  <= seen_next;
            adv_reg   <= adv_next;
            clr_reg   <= clr_next;
            fwd_reg   <= wr;
        end
    end

    // Shadow copy of pattern entry zero
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.addr == '0)
        begin
            first_reg <= wr.data;
        end
    end

endmodule

// ===== tb/sv/tb_fuzzy_subsequence_scorer.sv =====
module tb_fuzzy_subsequence_scorer;
    import fss_pkg::*;

    localparam int STR_MAX     = 128;
    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 200000;
    // Pattern lengths walked through by the random part; later phases pick small ones
    localparam int PHASE_LEN [15] = '{1, 2, 3, 5, 128, 4, 255, 8, 129, 0, 2, 64, 6, 1, 3};

    // One expected result beat
    typedef struct packed
    {
        logic               matched;
        logic [SCORE_W-1:0] score;
    } score_rec_t;

    // Tracks pattern, length and string progress; predicts and checks scores
    class match_tracker;
        logic [CHAR_W-1:0] pat_mem [PAT_DEPTH];
        logic [LEN_W-1:0]  pat_len;
        int unsigned       hit_pos;
        int unsigned       run_count;
        int unsigned       seen;
        bit                prev_hit;
        bit                lead_bonus;
        score_rec_t        pending_scores[$];
        int unsigned       fails;

        function new();
            pat_len = '0;
            fails   = 0;
            foreach (pat_mem[i])
            begin
                pat_mem[i] = '0;
            end
            clear_string();
        endfunction

        function void clear_string();
            hit_pos    = 0;
            run_count  = 0;
            seen       = 0;
            prev_hit   = 1'b0;
            lead_bonus = 1'b0;
        endfunction

        function void set_length(logic [LEN_W-1:0] v);
            pat_len = v;
        endfunction

        // Fold A-Z onto a-z; nothing else changes
        function logic [CHAR_W-1:0] lower(logic [CHAR_W-1:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                return c | CASE_OFFSET;
            end
            return c;
        endfunction

        // Update on one accepted input beat; queue a score when a string closes
        function void apply_beat(op_t op, logic [PAT_AW-1:0] idx, logic [CHAR_W-1:0] code,
                                 logic hc, logic se);
            logic [CHAR_W-1:0] c;
            int unsigned       eff;
            score_rec_t        rec;
            c   = lower(code);
            eff = (pat_len > PAT_DEPTH) ? PAT_DEPTH : pat_len;
            if (op == OP_WRITE)
            begin
                pat_mem[idx] = c;
                return;
            end
            if (hc && seen < STR_MAX - 1)
            begin
                if (seen == 0 && eff > 0 && c == pat_mem[0])
                begin
                    lead_bonus = 1'b1;
                end
                if (hit_pos < eff && c == pat_mem[hit_pos])
                begin
                    if (hit_pos == 0)
                    begin
                        run_count = 1;
                    end
                    else if (prev_hit)
                    begin
                        run_count++;
                    end
                    hit_pos++;
                    prev_hit = 1'b1;
                end
                else
                begin
                    prev_hit = 1'b0;
                end
                seen++;
            end
            if (!se)
            begin
                return;
            end
            rec.matched = (eff > 0) && (hit_pos >= eff);
            rec.score   = rec.matched ? SCORE_W'(run_count + lead_bonus) : '0;
            pending_scores.push_back(rec);
            clear_string();
        endfunction

        function void check_score(logic m, logic [SCORE_W-1:0] s);
            score_rec_t rec;
            if (pending_scores.size() == 0)
            begin
                $error("unexpected result beat: matched %0d score %0d", m, s);
                fails++;
                return;
            end
            rec = pending_scores.pop_front();
            if (m !== rec.matched)
            begin
                $error("matched: expected %0d, got %0d", rec.matched, m);
                fails++;
            end
            if (s !== rec.score)
            begin
                $error("score: expected %0d, got %0d", rec.score, s);
                fails++;
            end
        endfunction

        function int pending();
            return pending_scores.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [PAT_AW-1:0]  pattern_index;
    logic [CHAR_W-1:0]  char_code;
    logic               has_char;
    logic               string_end;
    logic               out_valid;
    logic               out_ready;
    logic               matched;
    logic [SCORE_W-1:0] score;

    match_tracker       tracker;
    logic [CHAR_W-1:0]  pat_bytes [PAT_DEPTH];
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;
    int unsigned        beat_count;
    int unsigned        cycle_count;

    fuzzy_subsequence_scorer #(
        .MAX_LEN (STR_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .pattern_index (pattern_index),
        .char_code     (char_code),
        .has_char      (has_char),
        .string_end    (string_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .score         (score)
    );

    always #1 clk = ~clk;

    // Cycle guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fuzzy_subsequence_scorer: mismatch");
            $finish;
        end
    end

    // Result side: random backpressure, check on every accepted beat
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_score(matched, score);
        end
    end

    // Mostly a small alphabet so strings hit the pattern; sometimes any byte
    function automatic logic [CHAR_W-1:0] pick_char();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(99) < 75)
        begin
            c = 8'(8'h61 + $urandom_range(4));
            if ($urandom_range(1) == 1)
            begin
                c = c & ~CASE_OFFSET;
            end
        end
        else
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // Swap the case of a letter half the time
    function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
        logic is_letter;
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        if (is_letter && $urandom_range(1) == 1)
        begin
            return c ^ CASE_OFFSET;
        end
        return c;
    endfunction

    // Drive one input beat and hold it until accepted
    task automatic send_beat(op_t op, logic [PAT_AW-1:0] idx, logic [CHAR_W-1:0] code,
                             logic hc, logic se);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        pattern_index <= idx;
        char_code     <= code;
        has_char      <= hc;
        string_end    <= se;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        tracker.apply_beat(op, idx, code, hc, se);
        beat_count++;
        if (beat_count == ITEM_TARGET / 3)
        begin
            send_idle_pct = 57;
            recv_idle_pct = 21;
        end
        else if (beat_count == 2 * ITEM_TARGET / 3)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic write_pat(logic [PAT_AW-1:0] idx, logic [CHAR_W-1:0] val);
        pat_bytes[idx] = val;
        send_beat(OP_WRITE, idx, val, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic cand(logic [CHAR_W-1:0] c, logic hc, logic se);
        send_beat(OP_CAND, 7'($urandom_range(127)), c, hc, se);
    endtask

    // Drop valid and wait until every result is in and the pipe has settled
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        tracker.set_length(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Modes: 0 pattern with noise, 1 random bytes, 2 long noise lead-in, 3 empty
    task automatic send_string(int eff, int mode);
        logic [CHAR_W-1:0] chars[$];
        int                drop_at;
        int                k;
        bit                empty_tail;
        logic              tail;
        drop_at    = ($urandom_range(4) == 0) ? int'($urandom_range(eff)) : -1;
        empty_tail = ($urandom_range(6) == 0);
        if (mode == 2)
        begin
            repeat ($urandom_range(130, 120)) chars.push_back(pick_char());
        end
        if (mode == 0 || mode == 2)
        begin
            for (k = 0; k < eff; k++)
            begin
                if (mode == 0 && $urandom_range(3) == 0)
                begin
                    repeat ($urandom_range(2, 1)) chars.push_back(pick_char());
                end
                if (k != drop_at)
                begin
                    chars.push_back(flip_case(pat_bytes[k]));
                end
            end
        end
        else if (mode == 1)
        begin
            repeat ($urandom_range(12)) chars.push_back(pick_char());
        end

        if (chars.size() == 0)
        begin
            cand(8'($urandom_range(255)), 1'b0, 1'b1);
            return;
        end
        for (k = 0; k < chars.size(); k++)
        begin
            // occasional pattern rewrite or no-op beat inside the string
            if ($urandom_range(49) == 0)
            begin
                write_pat(7'($urandom_range(127)), pick_char());
            end
            else if ($urandom_range(49) == 0)
            begin
                cand(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            tail = (k == chars.size() - 1) && !empty_tail;
            cand(chars[k], 1'b1, tail);
        end
        if (empty_tail)
        begin
            cand(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int phase;
        int plen;
        int eff;
        int s;
        int r;
        int k;
        tracker       = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        opcode        = OP_WRITE;
        pattern_index = '0;
        char_code     = '0;
        has_char      = 1'b0;
        string_end    = 1'b0;
        out_ready     = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 57;
        beat_count    = 0;
        cycle_count   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset: never matched
        cand("a", 1'b1, 1'b0);
        cand("b", 1'b1, 1'b1);

        // Fill the whole store so no later read hits an unwritten entry
        for (k = 0; k < PAT_DEPTH; k++)
        begin
            write_pat(7'(k), pick_char());
        end

        // Pattern "a", zero byte, 0xFF; written with an upper-case A
        write_length(8'd3);
        write_pat(7'd0, "A");
        write_pat(7'd1, 8'h00);
        write_pat(7'd2, 8'hFF);
        write_pat(7'd127, 8'hFF);
        // exact match from the first byte: run plus start bonus
        cand("a", 1'b1, 1'b0);
        cand(8'h00, 1'b1, 1'b0);
        cand(8'hFF, 1'b1, 1'b1);
        // upper-case candidate, broken run, fold boundaries
        cand("x", 1'b1, 1'b0);
        cand("A", 1'b1, 1'b0);
        cand("Z", 1'b1, 1'b0);
        cand(8'h00, 1'b1, 1'b0);
        cand("[", 1'b1, 1'b0);
        cand(8'hFF, 1'b1, 1'b1);
        // no-op beat and pattern rewrite in the middle of a string
        cand("A", 1'b1, 1'b0);
        cand(8'h00, 1'b0, 1'b0);
        write_pat(7'd1, 8'h00);
        cand(8'h00, 1'b1, 1'b0);
        cand(8'hFF, 1'b1, 1'b1);
        // empty string
        cand(8'hFF, 1'b0, 1'b1);
        // partial match closed by a beat with no byte
        cand("a", 1'b1, 1'b0);
        cand("@", 1'b1, 1'b0);
        cand(8'h00, 1'b0, 1'b1);

        // Random phases, one pattern length each
        phase = 0;
        while (beat_count < ITEM_TARGET)
        begin
            plen = (phase < 15) ? PHASE_LEN[phase] : int'($urandom_range(12, 1));
            write_length(8'(plen));
            eff = (plen > PAT_DEPTH) ? PAT_DEPTH : plen;
            if (eff <= 16)
            begin
                for (k = 0; k < eff; k++)
                begin
                    write_pat(7'(k), pick_char());
                end
            end
            if (eff >= 64)
            begin
                send_string(eff, 0);
                send_string(eff, 1);
            end
            else
            begin
                for (s = 0; s < 12; s++)
                begin
                    r = $urandom_range(99);
                    if (phase == 1 && s == 0)
                    begin
                        send_string(eff, 2);
                    end
                    else if (r < 65)
                    begin
                        send_string(eff, 0);
                    end
                    else if (r < 88)
                    begin
                        send_string(eff, 1);
                    end
                    else
                    begin
                        send_string(eff, 3);
                    end
                end
            end
            phase++;
        end

        drain();
        if (tracker.fails == 0 && tracker.pending() == 0)
        begin
            $display("fuzzy_subsequence_scorer: match");
        end
        else
        begin
            if (tracker.pending() != 0)
            begin
                $error("%0d expected results never arrived", tracker.pending());
            end
            $display("fuzzy_subsequence_scorer: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fss_pkg.sv
design/fss_pattern_mem.sv
design/fss_match_core.sv
design/fuzzy_subsequence_scorer.sv
tb/sv/tb_fuzzy_subsequence_scorer.sv
